@@ hdl/fbpa_pkg.sv @@
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

	// Pool geometry.
	localparam int NUM_BLOCKS = 32;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

	// Field and register widths.
	localparam int ADDR_W  = 32;
	localparam int BSIZE_W = 16;
	localparam int WIDE_W  = ADDR_W + 1;
	localparam int PROD_W  = IDX_W + BSIZE_W;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

	// Request kinds.
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd1;
	localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

	// Access request to the order list memory.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

@@ hdl/fbpa_list_ram.sv @@
// Order list memory: one write and one registered read per cycle.
module fbpa_list_ram (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fbpa_pkg::ram_req_t       req,
	output logic [fbpa_pkg::IDX_W-1:0] rdata
);
	import fbpa_pkg::*;

	logic [IDX_W-1:0]      mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] written_q;

	// Entry storage, no reset.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Per-entry written flags; an unwritten entry holds its own index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (req.we) begin
			written_q[req.waddr] <= 1'b1;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= written_q[req.raddr] ? mem[req.raddr] : req.raddr;
		end
	end

endmodule

@@ hdl/fixed_block_pool_allocator.sv @@
// Fixed block pool allocator: control, list scan pipeline and result register.
// Flow: a request word is held, then checked; pool exhausted, outside pool or release from an empty
// pool go straight to the result register, an allocate reads one list entry through the scan pipeline,
// any other release reads the used part one entry per cycle, then parks the freed index if found.
// Throughput: one request at a time; the next word is taken no earlier than the edge that can take the result word.
// Reset clears the count and the list reads as block i at entry i at once.
module fixed_block_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [fbpa_pkg::ADDR_W-1:0]   address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fbpa_pkg::STAT_W-1:0]   status,
	output logic [fbpa_pkg::ADDR_W-1:0]   granted_address,
	input  logic                          cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_data
);
	import fbpa_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_TAIL,
		S_REPLY
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  pool_base_q;
	logic [BSIZE_W-1:0] block_bytes_q;
	logic [CNT_W-1:0]   count_q;

	logic               kind_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PROD_W-1:0]  last_off_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   end_q;
	logic [CNT_W-1:0]   end_m1_q;
	logic               found_q;
	logic [IDX_W-1:0]   freed_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;

	logic               v_s1;
	logic [CNT_W-1:0]   idx_s1;
	logic               v_s2;
	logic [CNT_W-1:0]   idx_s2;
	logic [IDX_W-1:0]   data_s2;
	logic [PROD_W-1:0]  prod_s2;

	ram_req_t           ram_req;
	logic [IDX_W-1:0]   ram_rdata;

	logic [WIDE_W-1:0]  entry_addr;
	logic [WIDE_W-1:0]  last_addr;
	logic               outside;
	logic               match;

	fbpa_list_ram u_list_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	// Address arithmetic, one bit wider than the bus so it cannot wrap.
	assign entry_addr = WIDE_W'(pool_base_q) + WIDE_W'(prod_s2);
	assign last_addr  = WIDE_W'(pool_base_q) + WIDE_W'(last_off_q);
	assign outside    = (addr_q < pool_base_q) || (WIDE_W'(addr_q) > last_addr);
	assign match      = !found_q && (entry_addr == WIDE_W'(addr_q));

	// Memory accesses: sequential reads of the scan range, shift-down writes
	// behind the match point, and the parked freed index at the end.
	always_comb begin
		ram_req.re    = (state_q == S_SCAN) && (rd_idx_q != end_q);
		ram_req.raddr = rd_idx_q[IDX_W-1:0];
		if (state_q == S_TAIL) begin
			ram_req.we    = found_q;
			ram_req.waddr = IDX_W'(count_q - CNT_W'(1));
			ram_req.wdata = freed_q;
		end else begin
			ram_req.we    = (state_q == S_SCAN) && v_s2 && found_q && (kind_q == KIND_RELEASE);
			ram_req.waddr = IDX_W'(idx_s2 - CNT_W'(1));
			ram_req.wdata = data_s2;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_bytes_q <= BSIZE_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POOL_BASE:   pool_base_q   <= cfg_data;
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan pipeline: read data, then the block offset product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ram_req.re;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q;
		idx_s2  <= idx_s1;
		data_s2 <= ram_rdata;
		prod_s2 <= PROD_W'(ram_rdata) * PROD_W'(block_bytes_q);
	end

	// Request payload and scan bookkeeping.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			kind_q     <= kind;
			addr_q     <= address;
			last_off_q <= PROD_W'(LAST_IDX) * PROD_W'(block_bytes_q);
		end
		if (state_q == S_SCAN && v_s2 && match) begin
			freed_q <= data_s2;
		end
	end

	// Control sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			rd_idx_q        <= '0;
			end_q           <= '0;
			end_m1_q        <= '0;
			found_q         <= 1'b0;
			res_status_q    <= ST_GRANTED;
			res_addr_q      <= '0;
			out_valid       <= 1'b0;
			status          <= ST_GRANTED;
			granted_address <= '0;
		end else begin
			// The result word register loads a finished request or empties once taken.
			if (state_q == S_REPLY && (!out_valid || out_ready)) begin
				out_valid       <= 1'b1;
				status          <= res_status_q;
				granted_address <= res_addr_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					found_q    <= 1'b0;
					res_addr_q <= '0;
					if (kind_q == KIND_ALLOC) begin
						if (count_q == FULL_CNT) begin
							res_status_q <= ST_EXHAUSTED;
							state_q      <= S_REPLY;
						end else begin
							rd_idx_q <= count_q;
							end_q    <= count_q + CNT_W'(1);
							end_m1_q <= count_q;
							state_q  <= S_SCAN;
						end
					end else if (outside) begin
						res_status_q <= ST_OUTSIDE;
						state_q      <= S_REPLY;
					end else if (count_q == '0) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_REPLY;
					end else begin
						rd_idx_q <= '0;
						end_q    <= count_q;
						end_m1_q <= count_q - CNT_W'(1);
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ram_req.re) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (v_s2) begin
						if (kind_q == KIND_ALLOC) begin
							res_status_q <= ST_GRANTED;
							res_addr_q   <= entry_addr[ADDR_W-1:0];
							count_q      <= count_q + CNT_W'(1);
							state_q      <= S_REPLY;
						end else begin
							if (match) begin
								found_q <= 1'b1;
							end
							if (idx_s2 == end_m1_q) begin
								state_q <= S_TAIL;
							end
						end
					end
				end
				S_TAIL: begin
					if (found_q) begin
						count_q      <= count_q - CNT_W'(1);
						res_status_q <= ST_RELEASED;
					end else begin
						res_status_q <= ST_NOT_FOUND;
					end
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The count of blocks in use never exceeds the pool.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("used block count beyond pool size");

	// The list is only written while a release scan or its tail runs.
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> ((state_q == S_SCAN && kind_q == KIND_RELEASE) || state_q == S_TAIL))
		else $error("order list written outside a release");

	// The count moves only when a result is about to be formed.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (state_q == S_REPLY))
		else $error("used count changed without a result");

	// Only a grant carries a nonzero address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_GRANTED) |-> (granted_address == '0))
		else $error("address on a non-grant result word");

	// Shift writes stay behind the read pointer, so no read sees a stale entry.
	a_write_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && state_q == S_SCAN) |-> (CNT_W'(ram_req.waddr) < rd_idx_q))
		else $error("shift write overtook the scan read pointer");

endmodule
